@@ hw/rtl/lzbe_pkg.sv @@
`default_nettype none

package lzbe_pkg;

    localparam int MAX_LENGTH = 256;

    localparam int ACTION_W = 3;
    localparam int SYMBOL_W = 8;
    localparam int OFFSET_W = 5;
    localparam int LENGTH_W = 9;
    localparam int BYTE_W   = 8;

    localparam int GAMMA_V_W = 8;
    localparam int GAMMA_W   = 2 * GAMMA_V_W - 1;
    localparam int GLEN_W    = 4;
    localparam int OFFCODE_W = 6;
    localparam int CODE_W    = OFFCODE_W + GAMMA_W;
    localparam int LEN_W     = 5;

    localparam int ACC_W     = 32;
    localparam int ACC_CNT_W = 5;
    localparam int SHAMT_W   = 6;

    localparam int TQ_DEPTH = 4;
    localparam int TQ_CNT_W = 3;
    localparam int TQ_IDX_W = 2;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_CNT_W = 3;
    localparam int OQ_IDX_W = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_RAW       = 3'd0,
        ACT_FIRST_LIT = 3'd1,
        ACT_LIT       = 3'd2,
        ACT_MATCH     = 3'd3,
        ACT_FINISH    = 3'd4
    } action_t;

    typedef struct packed {
        logic              fin;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } tok_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } obyte_t;

endpackage

`default_nettype wire

@@ hw/rtl/lzbe_front.sv @@
`default_nettype none

module lzbe_front
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic [lzbe_pkg::ACTION_W-1:0]   action,
    input  wire logic [lzbe_pkg::SYMBOL_W-1:0]   symbol,
    input  wire logic [lzbe_pkg::OFFSET_W-1:0]   match_offset,
    input  wire logic [lzbe_pkg::LENGTH_W-1:0]   match_length,
    input  wire logic                            bit_value,
    output logic                                 tok_valid,
    output lzbe_pkg::tok_t                       tok_head,
    input  wire logic                            tok_pop
);
    import lzbe_pkg::*;

    tok_t                tok;
    logic                tok_keep;
    logic                push_fire;
    logic [TQ_CNT_W-1:0] wr_pos;
    logic [TQ_IDX_W-1:0] wr_idx;

    tok_t                q_reg  [TQ_DEPTH];
    tok_t                q_next [TQ_DEPTH];
    logic [TQ_CNT_W-1:0] cnt_reg;
    logic [TQ_CNT_W-1:0] cnt_next;

    always_comb
    begin
        logic [LENGTH_W-1:0]  lsat;
        logic [GAMMA_V_W-1:0] v;
        logic [2:0]           top;
        logic [GAMMA_W-1:0]   g;
        logic [GLEN_W-1:0]    glen;
        logic [OFFCODE_W-1:0] off_val;
        logic [2:0]           off_len;
        logic [OFFCODE_W-1:0] code5;

        tok      = '0;
        tok_keep = 1'b1;
        lsat     = (match_length > LENGTH_W'(MAX_LENGTH)) ? LENGTH_W'(MAX_LENGTH)
                                                          : match_length;
        v        = (lsat >= LENGTH_W'(1)) ? GAMMA_V_W'(lsat - LENGTH_W'(1)) : '0;
        if (v == '0)
        begin
            v = GAMMA_V_W'(1);
        end
        top = '0;
        for (int i = 0; i < GAMMA_V_W; i++)
        begin
            if (v[i])
            begin
                top = 3'(i);
            end
        end
        g = GAMMA_W'(1);
        for (int k = 0; k < GAMMA_V_W - 1; k++)
        begin
            if (3'(k) < top)
            begin
                g[2*k+1] = v[k];
            end
        end
        glen  = GLEN_W'({top, 1'b1});
        code5 = (match_offset <= OFFSET_W'(10)) ? OFFCODE_W'(match_offset + 6'd10)
                                                : OFFCODE_W'(match_offset + 6'd9);
        if (match_offset == OFFSET_W'(1))
        begin
            off_val = OFFCODE_W'(0);
            off_len = 3'd3;
        end
        else if (match_offset == OFFSET_W'(11))
        begin
            off_val = OFFCODE_W'(2);
            off_len = 3'd4;
        end
        else
        begin
            off_val = {1'b0, code5[OFFSET_W-1:0]};
            off_len = 3'd6;
        end

        unique case (action_t'(action))
            ACT_RAW:
            begin
                tok.len  = LEN_W'(1);
                tok.code = CODE_W'(bit_value);
            end
            ACT_FIRST_LIT:
            begin
                tok.len  = LEN_W'(1);
                tok.code = CODE_W'(symbol != SYMBOL_W'(1));
            end
            ACT_LIT:
            begin
                if (symbol == SYMBOL_W'(2))
                begin
                    tok.len  = LEN_W'(6);
                    tok.code = CODE_W'(6'b010101);
                end
                else
                begin
                    tok.len  = LEN_W'(2);
                    tok.code = CODE_W'({1'b1, symbol != SYMBOL_W'(1)});
                end
            end
            ACT_MATCH:
            begin
                tok.len  = LEN_W'(off_len) + LEN_W'(glen);
                tok.code = (CODE_W'(off_val) << glen) | CODE_W'(g);
            end
            ACT_FINISH:
            begin
                tok.fin = 1'b1;
            end
            default:
            begin
                tok_keep = 1'b0;
            end
        endcase
    end

    assign full      = (cnt_reg == TQ_CNT_W'(TQ_DEPTH));
    assign push_fire = push && !full;
    assign tok_valid = (cnt_reg != '0);
    assign tok_head  = q_reg[0];
    assign wr_pos    = cnt_reg - TQ_CNT_W'(tok_pop);
    assign wr_idx    = wr_pos[TQ_IDX_W-1:0];

    always_comb
    begin
        for (int i = 0; i < TQ_DEPTH; i++)
        begin
            q_next[i] = q_reg[i];
            if (tok_pop && (i < TQ_DEPTH - 1))
            begin
                q_next[i] = q_reg[(i+1) % TQ_DEPTH];
            end
            if (push_fire && tok_keep && (wr_idx == TQ_IDX_W'(i)))
            begin
                q_next[i] = tok;
            end
        end
        cnt_next = cnt_reg + TQ_CNT_W'(push_fire && tok_keep) - TQ_CNT_W'(tok_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= TQ_CNT_W'(TQ_DEPTH))
        else $error("token queue overfilled");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        tok_pop |-> tok_valid)
        else $error("token popped from empty queue");

    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (full && !tok_pop) |=> full)
        else $error("token queue lost an entry");

endmodule

`default_nettype wire

@@ hw/rtl/lzbe_back.sv @@
`default_nettype none

module lzbe_back
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         tok_valid,
    input  wire lzbe_pkg::tok_t               tok_head,
    output logic                              tok_pop,
    output logic                              empty,
    input  wire logic                         pop,
    output logic [lzbe_pkg::BYTE_W-1:0]       out_byte,
    output logic                              is_last
);
    import lzbe_pkg::*;

    logic [ACC_W-1:0]     acc_reg;
    logic [ACC_W-1:0]     acc_next;
    logic [ACC_CNT_W-1:0] cnt_reg;
    logic [ACC_CNT_W-1:0] cnt_next;

    obyte_t               oq_reg  [OQ_DEPTH];
    obyte_t               oq_next [OQ_DEPTH];
    logic [OQ_CNT_W-1:0]  oq_cnt_reg;
    logic [OQ_CNT_W-1:0]  oq_cnt_next;

    logic                 pop_fire;
    logic                 space;
    logic                 emit;
    logic                 emit_fin;
    obyte_t               emit_byte;
    logic [SHAMT_W-1:0]   shamt;
    logic [OQ_CNT_W-1:0]  wr_pos;
    logic [OQ_IDX_W-1:0]  wr_idx;

    assign pop_fire = pop && !empty;
    assign space    = (oq_cnt_reg != OQ_CNT_W'(OQ_DEPTH)) || pop_fire;
    assign shamt    = SHAMT_W'(ACC_W) - SHAMT_W'(cnt_reg) - SHAMT_W'(tok_head.len);

    always_comb
    begin
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        tok_pop   = 1'b0;
        emit      = 1'b0;
        emit_fin  = 1'b0;
        emit_byte = '{data: acc_reg[ACC_W-1 -: BYTE_W], last: 1'b0};
        if (cnt_reg >= ACC_CNT_W'(BYTE_W))
        begin
            if (space)
            begin
                emit     = 1'b1;
                acc_next = acc_reg << BYTE_W;
                cnt_next = cnt_reg - ACC_CNT_W'(BYTE_W);
            end
        end
        else if (tok_valid)
        begin
            if (!tok_head.fin)
            begin
                tok_pop  = 1'b1;
                acc_next = acc_reg | (ACC_W'(tok_head.code) << shamt[SHAMT_W-2:0]);
                cnt_next = cnt_reg + ACC_CNT_W'(tok_head.len);
            end
            else if (cnt_reg == '0)
            begin
                tok_pop = 1'b1;
            end
            else if (space)
            begin
                tok_pop        = 1'b1;
                emit           = 1'b1;
                emit_fin       = 1'b1;
                emit_byte.last = 1'b1;
                acc_next       = '0;
                cnt_next       = '0;
            end
        end
    end

    assign wr_pos = oq_cnt_reg - OQ_CNT_W'(pop_fire);
    assign wr_idx = wr_pos[OQ_IDX_W-1:0];

    always_comb
    begin
        for (int i = 0; i < OQ_DEPTH; i++)
        begin
            oq_next[i] = oq_reg[i];
            if (pop_fire && (i < OQ_DEPTH - 1))
            begin
                oq_next[i] = oq_reg[(i+1) % OQ_DEPTH];
            end
            if (emit && (wr_idx == OQ_IDX_W'(i)))
            begin
                oq_next[i] = emit_byte;
            end
        end
        oq_cnt_next = oq_cnt_reg + OQ_CNT_W'(emit) - OQ_CNT_W'(pop_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            cnt_reg    <= '0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            acc_reg    <= acc_next;
            cnt_reg    <= cnt_next;
            oq_cnt_reg <= oq_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oq_reg <= oq_next;
    end

    assign empty    = (oq_cnt_reg == '0);
    assign out_byte = oq_reg[0].data;
    assign is_last  = oq_reg[0].last;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= ACC_CNT_W'(BYTE_W - 1 + CODE_W))
        else $error("bit accumulator overfilled");

    a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        oq_cnt_reg <= OQ_CNT_W'(OQ_DEPTH))
        else $error("output queue overfilled");

    a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fin |=> (cnt_reg == '0) && (acc_reg == '0))
        else $error("finish left bits pending");

    a_load_below_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_pop && !tok_head.fin) |-> (cnt_reg < ACC_CNT_W'(BYTE_W)))
        else $error("token loaded over a whole pending byte");

endmodule

`default_nettype wire

@@ hw/rtl/lz_token_bitstream_encoder.sv @@
`default_nettype none
// An accepted token waits in the token queue until the bit packer loads it;
// a finish token flushes any pending bits into the byte queue as a last byte.
// The packer loads a token only with under 8 bits pending, then moves each
// byte it completes (up to 3) to the byte queue, stalling while that is full.
// The 4-entry token queue and 4-entry byte queue let push and pop stall apart.
// Reset (rst_n low, asynchronous) empties both queues and clears pending bits.

module lz_token_bitstream_encoder
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic [lzbe_pkg::ACTION_W-1:0]   action,
    input  wire logic [lzbe_pkg::SYMBOL_W-1:0]   symbol,
    input  wire logic [lzbe_pkg::OFFSET_W-1:0]   match_offset,
    input  wire logic [lzbe_pkg::LENGTH_W-1:0]   match_length,
    input  wire logic                            bit_value,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic [lzbe_pkg::BYTE_W-1:0]          out_byte,
    output logic                                 is_last
);
    import lzbe_pkg::*;

    logic tok_valid;
    tok_t tok_head;
    logic tok_pop;

    lzbe_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .action       (action),
        .symbol       (symbol),
        .match_offset (match_offset),
        .match_length (match_length),
        .bit_value    (bit_value),
        .tok_valid    (tok_valid),
        .tok_head     (tok_head),
        .tok_pop      (tok_pop)
    );

    lzbe_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok_valid),
        .tok_head  (tok_head),
        .tok_pop   (tok_pop),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .is_last   (is_last)
    );

endmodule

`default_nettype wire
